@@ sv/qte_pkg.sv @@
package qte_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int ATAN_TABLE_LEN  = 24;
  localparam int RUN_STEPS       = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS : ATAN_TABLE_LEN;
  localparam int SQRT_STEPS      = 29;
  localparam int SHIFT_R         = (COMPONENT_WIDTH > 16) ? COMPONENT_WIDTH - 16 : 0;
  localparam int SHIFT_L         = (COMPONENT_WIDTH < 16) ? 16 - COMPONENT_WIDTH : 0;

  localparam int CW = 34;
  localparam int ZW = 24;
  localparam int NW = 58;

  localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [16:0]   PITCH_LIMIT = 17'sd12868;
  localparam logic signed [16:0]   FULL_LIMIT  = 17'sd25736;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cvec_t;

  typedef struct packed {
    logic [NW-1:0] n;
    logic [NW-1:0] root;
  } sqv_t;

  function automatic logic signed [15:0] to_q14(logic signed [COMPONENT_WIDTH-1:0] v);
    logic signed [31:0] wide;
    wide = 32'(v);
    if (COMPONENT_WIDTH > 16) return 16'(wide >>> SHIFT_R);
    else return 16'(wide <<< SHIFT_L);
  endfunction

  function automatic logic signed [ZW-1:0] atan_q20(logic [4:0] idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      5'd0:  r = 24'sd823550;
      5'd1:  r = 24'sd486170;
      5'd2:  r = 24'sd256879;
      5'd3:  r = 24'sd130396;
      5'd4:  r = 24'sd65451;
      5'd5:  r = 24'sd32757;
      5'd6:  r = 24'sd16383;
      5'd7:  r = 24'sd8192;
      5'd8:  r = 24'sd4096;
      5'd9:  r = 24'sd2048;
      5'd10: r = 24'sd1024;
      5'd11: r = 24'sd512;
      5'd12: r = 24'sd256;
      5'd13: r = 24'sd128;
      5'd14: r = 24'sd64;
      5'd15: r = 24'sd32;
      5'd16: r = 24'sd16;
      5'd17: r = 24'sd8;
      5'd18: r = 24'sd4;
      5'd19: r = 24'sd2;
      5'd20: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/qte_sqrt_cell.sv @@
module qte_sqrt_cell (
  input  logic               clk_i,
  input  logic [4:0]         step_i,
  input  qte_pkg::sqv_t      v_i,
  output qte_pkg::sqv_t      v_o
);
  import qte_pkg::*;

  logic [NW-1:0] bitv;
  logic [NW-1:0] trial;
  sqv_t          v_d, v_q;

  always_comb begin
    bitv  = NW'(1) << (7'(step_i) << 1);
    trial = v_i.root + bitv;
    if (v_i.n >= trial) begin
      v_d.n    = v_i.n - trial;
      v_d.root = (v_i.root >> 1) + bitv;
    end else begin
      v_d.n    = v_i.n;
      v_d.root = v_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

@@ sv/qte_cordic_cell.sv @@
module qte_cordic_cell (
  input  logic           clk_i,
  input  logic [4:0]     step_i,
  input  qte_pkg::cvec_t v_i,
  output qte_pkg::cvec_t v_o
);
  import qte_pkg::*;

  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] da;
  cvec_t                v_d, v_q;

  always_comb begin
    dx = v_i.y >>> step_i;
    dy = v_i.x >>> step_i;
    da = atan_q20(step_i);
    v_d.zero = v_i.zero;
    if (v_i.y >= 0) begin
      v_d.x = v_i.x + dx;
      v_d.y = v_i.y - dy;
      v_d.z = v_i.z + da;
    end else begin
      v_d.x = v_i.x - dx;
      v_d.y = v_i.y + dy;
      v_d.z = v_i.z - da;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

@@ sv/quaternion_to_euler_angles.sv @@
// Quaternion (w,x,y,z, signed Q1.14) to ZYX Euler angles in radians, signed Q3.13.
// One item is taken every clock cycle (busy_o stays low); each result shows
// on the angle ports with done_o for exactly one cycle, from the 50th clock edge
// after the edge that takes its item until the next edge, and must be captured
// then since the block cannot be stalled.
// Latency is set by the 29-cell square-root chain for the pitch cosine term
// and the 16-cell CORDIC chains, plus the product, sum and rounding stages.
module quaternion_to_euler_angles (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  output logic                                       busy_o,
  input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_w_i,
  input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_x_i,
  input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_y_i,
  input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_z_i,
  output logic                                       done_o,
  output logic signed [14:0]                         pitch_angle_o,
  output logic signed [15:0]                         yaw_angle_o,
  output logic signed [15:0]                         roll_angle_o
);
  import qte_pkg::*;

  localparam int LAT = 4 + SQRT_STEPS + 1 + RUN_STEPS + 1;

  logic [LAT-1:0] vld_q, vld_d;

  logic signed [15:0] w_q, x_q, y_q, z_q;
  logic signed [31:0] wy_q, zx_q, wz_q, xy_q, wx_q, yz_q, yy_q, zz_q, xx_q;

  logic signed [32:0] dif;
  logic signed [33:0] s2;
  logic signed [29:0] s_d, s_q, s4_q;
  logic signed [CW-1:0] ysy_q, ycx_q, rsy_q, rcx_q;
  logic signed [CW-1:0] ysy4_q, ycx4_q, rsy4_q, rcx4_q;
  logic [59:0] ssq_q;

  sqv_t sq [SQRT_STEPS+1];

  logic signed [29:0]   sd_q   [SQRT_STEPS];
  logic signed [CW-1:0] ysyd_q [SQRT_STEPS];
  logic signed [CW-1:0] ycxd_q [SQRT_STEPS];
  logic signed [CW-1:0] rsyd_q [SQRT_STEPS];
  logic signed [CW-1:0] rcxd_q [SQRT_STEPS];

  cvec_t pre_d [3];
  cvec_t ch [3][RUN_STEPS+1];
  logic signed [CW-1:0] px [3];
  logic signed [CW-1:0] py [3];

  logic signed [ZW:0]  rz [3];
  logic signed [16:0]  rr [3];
  logic signed [16:0]  rc [3];
  logic signed [14:0]  pitch_q;
  logic signed [15:0]  yaw_q, roll_q;

  assign busy_o = 1'b0;

  always_comb begin
    vld_d = {vld_q[LAT-2:0], start_i & ~busy_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q  <= to_q14(quat_w_i);
    x_q  <= to_q14(quat_x_i);
    y_q  <= to_q14(quat_y_i);
    z_q  <= to_q14(quat_z_i);
    wy_q <= 32'(w_q * y_q);
    zx_q <= 32'(z_q * x_q);
    wz_q <= 32'(w_q * z_q);
    xy_q <= 32'(x_q * y_q);
    wx_q <= 32'(w_q * x_q);
    yz_q <= 32'(y_q * z_q);
    yy_q <= 32'(y_q * y_q);
    zz_q <= 32'(z_q * z_q);
    xx_q <= 32'(x_q * x_q);
  end

  always_comb begin
    dif = 33'(wy_q) - 33'(zx_q);
    s2  = 34'(dif) <<< 1;
    if (s2 > 34'sd268435456) s_d = 30'sd268435456;
    else if (s2 < -34'sd268435456) s_d = -30'sd268435456;
    else s_d = 30'(s2);
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    ysy_q  <= CW'(wz_q) + CW'(xy_q);
    ycx_q  <= CW'(34'sd134217728) - (CW'(yy_q) + CW'(zz_q));
    rsy_q  <= CW'(wx_q) + CW'(yz_q);
    rcx_q  <= CW'(34'sd134217728) - (CW'(yy_q) + CW'(xx_q));
    ssq_q  <= 60'(s_q * s_q);
    s4_q   <= s_q;
    ysy4_q <= ysy_q;
    ycx4_q <= ycx_q;
    rsy4_q <= rsy_q;
    rcx4_q <= rcx_q;
  end

  assign sq[0].n    = (NW'(1) << 56) - NW'(ssq_q);
  assign sq[0].root = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .step_i (5'(SQRT_STEPS - 1 - k)),
      .v_i    (sq[k]),
      .v_o    (sq[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    sd_q[0]   <= s4_q;
    ysyd_q[0] <= ysy4_q;
    ycxd_q[0] <= ycx4_q;
    rsyd_q[0] <= rsy4_q;
    rcxd_q[0] <= rcx4_q;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      sd_q[k]   <= sd_q[k-1];
      ysyd_q[k] <= ysyd_q[k-1];
      ycxd_q[k] <= ycxd_q[k-1];
      rsyd_q[k] <= rsyd_q[k-1];
      rcxd_q[k] <= rcxd_q[k-1];
    end
  end

  always_comb begin
    py[0] = CW'(sd_q[SQRT_STEPS-1]);
    px[0] = CW'(sq[SQRT_STEPS].root[28:0]);
    py[1] = ysyd_q[SQRT_STEPS-1];
    px[1] = ycxd_q[SQRT_STEPS-1];
    py[2] = rsyd_q[SQRT_STEPS-1];
    px[2] = rcxd_q[SQRT_STEPS-1];
    for (int c = 0; c < 3; c++) begin
      pre_d[c].zero = (px[c] == '0) && (py[c] == '0);
      if (px[c] < 0) begin
        if (py[c] >= 0) begin
          pre_d[c].x = py[c];
          pre_d[c].y = -px[c];
          pre_d[c].z = HALF_PI_Q20;
        end else begin
          pre_d[c].x = -py[c];
          pre_d[c].y = px[c];
          pre_d[c].z = -HALF_PI_Q20;
        end
      end else begin
        pre_d[c].x = px[c];
        pre_d[c].y = py[c];
        pre_d[c].z = '0;
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    always_ff @(posedge clk_i) begin
      ch[c][0] <= pre_d[c];
    end
    for (genvar i = 0; i < RUN_STEPS; i++) begin : g_step
      qte_cordic_cell u_cell (
        .clk_i  (clk_i),
        .step_i (5'(i)),
        .v_i    (ch[c][i]),
        .v_o    (ch[c][i+1])
      );
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rz[c] = (ZW+1)'(ch[c][RUN_STEPS].z) + (ZW+1)'(64);
      rr[c] = ch[c][RUN_STEPS].zero ? 17'sd0 : 17'(rz[c] >>> 7);
    end
    rc[0] = (rr[0] > PITCH_LIMIT) ? PITCH_LIMIT : (rr[0] < -PITCH_LIMIT) ? -PITCH_LIMIT : rr[0];
    for (int c = 1; c < 3; c++) begin
      rc[c] = (rr[c] > FULL_LIMIT) ? FULL_LIMIT : (rr[c] < -FULL_LIMIT) ? -FULL_LIMIT : rr[c];
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q <= 15'(rc[0]);
    yaw_q   <= 16'(rc[1]);
    roll_q  <= 16'(rc[2]);
  end

  assign done_o        = vld_q[LAT-1];
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;
  assign roll_angle_o  = roll_q;

endmodule

@@ sv/qte_checker.sv @@
module qte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               busy_i,
  input logic               done_i,
  input logic signed [14:0] pitch_angle_i,
  input logic signed [15:0] yaw_angle_i,
  input logic signed [15:0] roll_angle_i
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_i)
    else $error("busy raised");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (pitch_angle_i <= 15'sd12868) && (pitch_angle_i >= -15'sd12868))
    else $error("pitch out of range");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (yaw_angle_i <= 16'sd25736) && (yaw_angle_i >= -16'sd25736))
    else $error("yaw out of range");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> (roll_angle_i <= 16'sd25736) && (roll_angle_i >= -16'sd25736))
    else $error("roll out of range");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .busy_i        (busy_o),
  .done_i        (done_o),
  .pitch_angle_i (pitch_angle_o),
  .yaw_angle_i   (yaw_angle_o),
  .roll_angle_i  (roll_angle_o)
);

@@ tb/sv/quaternion_to_euler_angles_checker.sv @@
`timescale 1ns / 1ps

module quaternion_to_euler_angles_checker (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic                                       busy_i,
  input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_w_i,
  input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_x_i,
  input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_y_i,
  input  logic signed [qte_pkg::COMPONENT_WIDTH-1:0] quat_z_i,
  input  logic                                       done_i,
  input  logic signed [14:0]                         pitch_angle_i,
  input  logic signed [15:0]                         yaw_angle_i,
  input  logic signed [15:0]                         roll_angle_i,
  output int                                         fail_count_o,
  output int                                         pending_o,
  output int                                         angles_seen_o
);
  import qte_pkg::*;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll;
  } euler_t;

  localparam longint HALF_TURN_Q20 = 1647099;

  euler_t angles_q[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint norm_q14(logic signed [COMPONENT_WIDTH-1:0] v);
    longint w;
    w = v;
    if (COMPONENT_WIDTH > 16) return floor_shift(w, COMPONENT_WIDTH - 16);
    return w * (longint'(1) << (16 - COMPONENT_WIDTH));
  endfunction

  function automatic longint arc_table(int i);
    longint tbl[21];
    tbl = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096,
            2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 21) ? tbl[i] : 0;
  endfunction

  function automatic longint vector_angle(longint sy, longint cx);
    longint vx, vy, ang, t, dx, dy;
    vx = cx;
    vy = sy;
    ang = 0;
    if (vx == 0 && vy == 0) return 0;
    if (vx < 0) begin
      t = vx;
      if (vy >= 0) begin
        vx = vy; vy = -t; ang = HALF_TURN_Q20;
      end else begin
        vx = -vy; vy = t; ang = -HALF_TURN_Q20;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = floor_shift(vy, i);
      dy = floor_shift(vx, i);
      if (vy >= 0) begin
        vx += dx; vy -= dy; ang += arc_table(i);
      end else begin
        vx -= dx; vy += dy; ang -= arc_table(i);
      end
    end
    return ang;
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = floor_shift(a + 64, 7);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic euler_t quat_to_euler(logic signed [COMPONENT_WIDTH-1:0] qw, qx, qy, qz);
    longint w, x, y, z, s, c, ysq, one;
    euler_t e;
    w = norm_q14(qw);
    x = norm_q14(qx);
    y = norm_q14(qy);
    z = norm_q14(qz);
    one = longint'(1) << 28;
    s = 2 * (w * y - z * x);
    if (s > one) s = one;
    if (s < -one) s = -one;
    c = floor_sqrt(longint'(one * one) - s * s);
    e.pitch = 15'(round_q13(vector_angle(s, c), 12868));
    ysq = y * y;
    e.yaw = 16'(round_q13(vector_angle(w * z + x * y, one / 2 - (ysq + z * z)), 25736));
    e.roll = 16'(round_q13(vector_angle(w * x + y * z, one / 2 - (ysq + x * x)), 25736));
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    euler_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      pending_o = 0;
      angles_seen_o <= 0;
    end else begin
      if (start_i && !busy_i)
        angles_q.insert(angles_q.size(),
                        quat_to_euler(quat_w_i, quat_x_i, quat_y_i, quat_z_i));
      if (done_i) begin
        angles_seen_o <= angles_seen_o + 1;
        if (angles_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = angles_q.pop_front();
          if (pitch_angle_i !== e.pitch) report_mismatch("pitch", pitch_angle_i, e.pitch);
          if (yaw_angle_i !== e.yaw) report_mismatch("yaw", yaw_angle_i, e.yaw);
          if (roll_angle_i !== e.roll) report_mismatch("roll", roll_angle_i, e.roll);
        end
      end
      pending_o = angles_q.size();
    end
  end

endmodule

@@ tb/sv/quaternion_to_euler_angles_tb.sv @@
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;
  import qte_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 500;

  logic clk_i, rst_ni, start_i, busy_o, done_o;
  logic signed [COMPONENT_WIDTH-1:0] quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  logic signed [14:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o, roll_angle_o;
  int fail_count, pending, angles_seen, items_sent;
  int idle_cycles = 0;

  quaternion_to_euler_angles u_dut (.*);

  quaternion_to_euler_angles_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .quat_w_i, .quat_x_i, .quat_y_i,
    .quat_z_i, .done_i(done_o), .pitch_angle_i(pitch_angle_o), .yaw_angle_i(yaw_angle_o),
    .roll_angle_i(roll_angle_o), .fail_count_o(fail_count), .pending_o(pending),
    .angles_seen_o(angles_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (start_i && !busy_o || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_quat(int qw, int qx, int qy, int qz, bit gaps);
    int gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18)) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    quat_w_i <= COMPONENT_WIDTH'(qw);
    quat_x_i <= COMPONENT_WIDTH'(qx);
    quat_y_i <= COMPONENT_WIDTH'(qy);
    quat_z_i <= COMPONENT_WIDTH'(qz);
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic int pick_component();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 32767) - 16384;
      1: return 16384;
      2: return -16384;
      3: return $urandom_range(0, 65535) - 32768;
      4: return $urandom_range(0, 200) - 100;
      default: return $urandom_range(0, 16384) - 8192;
    endcase
  endfunction

  task automatic send_unit_quat(bit gaps);
    real a, b, c, d, n;
    a = real'($urandom_range(0, 20000)) - 10000.0;
    b = real'($urandom_range(0, 20000)) - 10000.0;
    c = real'($urandom_range(0, 20000)) - 10000.0;
    d = real'($urandom_range(0, 20000)) - 10000.0;
    n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
    send_quat(int'(a / n * 16384.0), int'(b / n * 16384.0),
              int'(c / n * 16384.0), int'(d / n * 16384.0), gaps);
  endtask

  initial begin
    start_i = 1'b0;
    quat_w_i = '0; quat_x_i = '0; quat_y_i = '0; quat_z_i = '0;
    items_sent = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_quat(16384, 0, 0, 0, 0);
    send_quat(0, 0, 0, 0, 0);
    send_quat(-16384, 0, 0, 0, 0);
    send_quat(0, 16384, 0, 0, 0);
    send_quat(0, 0, 16384, 0, 0);
    send_quat(0, 0, 0, 16384, 0);
    send_quat(11585, 0, 11585, 0, 0);
    send_quat(11585, 0, -11585, 0, 0);
    send_quat(16384, 0, 16384, 0, 0);
    send_quat(16384, 16384, -16384, 16384, 0);
    send_quat(-32768, -32768, -32768, -32768, 0);
    send_quat(32767, 32767, 32767, 32767, 0);
    send_quat(-32768, 32767, -32768, 32767, 0);
    send_quat(8192, 8192, 8192, 8192, 0);
    send_quat(8192, -8192, 8192, -8192, 0);
    send_quat(0, 11585, 0, 11585, 0);
    send_quat(0, 0, 11585, -11585, 0);
    send_quat(1, -1, 1, -1, 0);

    // hold off until the pipeline drains
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2)
        drain();
      if (i % 100 < 30)
        send_unit_quat(0);
      else if ($urandom_range(0, 3) != 0)
        send_unit_quat(1);
      else
        send_quat(pick_component(), pick_component(), pick_component(), pick_component(), 1);
    end

    drain();
    repeat (60) @(posedge clk_i);
    $display("Sent %0d quaternions (directed corners, unit and raw random), checked %0d angles.",
             items_sent, angles_seen);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
sv/qte_pkg.sv
sv/qte_sqrt_cell.sv
sv/qte_cordic_cell.sv
sv/quaternion_to_euler_angles.sv
sv/qte_checker.sv
tb/sv/quaternion_to_euler_angles_checker.sv
tb/sv/quaternion_to_euler_angles_tb.sv
